// ===== hw/rtl/ocf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ocf_pkg
// Shared constants and types for the owning cycle finder.
// ----------------------------------------------------------------------------
package ocf_pkg;
  localparam int NODES          = 16;
  localparam int EDGES_PER_NODE = 8;
  localparam int FIELDS         = 64;
  localparam int NODE_W  = $clog2(NODES);
  localparam int EPN_W   = (EDGES_PER_NODE > 1) ? $clog2(EDGES_PER_NODE) : 1;
  localparam int ECNT_W  = $clog2(EDGES_PER_NODE + 1);
  localparam int DEPTH_W = $clog2(NODES + 1);
  localparam int EADDR_W = $clog2(NODES * EDGES_PER_NODE);
  localparam int FIELD_W = 6;
  localparam int NCNT_W  = 5;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_FIND  = 2'd2;

  localparam logic [1:0] ST_RING  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  localparam logic [1:0] COL_WHITE = 2'd0;
  localparam logic [1:0] COL_GREY  = 2'd1;
  localparam logic [1:0] COL_BLACK = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         from_node;
    logic [5:0]         field_index;
    logic [3:0]         to_node;
  } ocf_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] closing_node;
    logic [5:0] closing_field;
    logic [3:0] ring_member;
    logic       last;
  } ocf_out_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ocf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ocf_in_if / ocf_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ocf_in_if import ocf_pkg::*; ();
  logic    valid;
  logic    ready;
  ocf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ocf_out_if import ocf_pkg::*; ();
  logic     valid;
  logic     ready;
  ocf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ocf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ocf_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module ocf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/owning_cycle_finder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owning_cycle_finder_unit
// Depth-first ring finder over a loaded directed graph, run by a sequencer.
// ----------------------------------------------------------------------------
// Channel | Direction | Content
// in_     | sink      | cmd, from_node, field_index, to_node
// out_    | source    | status, closing_node, closing_field, ring_member, last
// cfg_    | APB write | node_count at address 0
// A load or clear is taken in idle; the unit is ready again on the next cycle
// unless a dropped load left a result item waiting. A find is accepted in idle,
// then probes roots, pops frames, examines edges (address, then the registered edge
// RAM read), scans stack entries and emits ring members one at a time.
// The input is not ready while a find runs or a result item waits; a waiting
// result item holds under out_ready low. Reset is synchronous.
// ----------------------------------------------------------------------------
module owning_cycle_finder_unit import ocf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  ocf_in_if.sink          in_ch,
  ocf_out_if.source       out_ch,
  input  wire logic       cfg_psel,
  input  wire logic       cfg_penable,
  input  wire logic       cfg_pwrite,
  input  wire logic [1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROOT  = 4'd1;
  localparam logic [3:0] S_TOP   = 4'd2;
  localparam logic [3:0] S_EDGE  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_EMIT  = 4'd5;

  logic [3:0]           state_r;
  logic [NCNT_W-1:0]    node_count_r;
  logic [ECNT_W-1:0]    ecnt_r [NODES];
  logic [1:0]           col_r [NODES];
  logic [NODE_W-1:0]    snode_r [NODES];
  logic [ECNT_W-1:0]    snext_r [NODES];
  logic [DEPTH_W-1:0]   depth_r;
  logic [DEPTH_W-1:0]   root_r;
  logic [DEPTH_W-1:0]   pos_r;
  logic [NODE_W-1:0]    at_r;
  logic [NODE_W-1:0]    tgt_r;
  logic [5:0]           fld_r;
  ocf_out_t             obuf_r;
  logic                 ovalid_r;

  logic [DEPTH_W-1:0]   nc;
  logic                 we;
  logic [EADDR_W-1:0]   waddr, raddr;
  logic [NODE_W+5:0]    wdata, rdata;
  ocf_in_t              ind;
  logic [NODE_W-1:0]    top_node;
  logic [ECNT_W-1:0]    top_next;
  logic                 out_load;

  assign ind = in_ch.data;
  assign nc = (node_count_r > NCNT_W'(NODES)) ? DEPTH_W'(NODES) : DEPTH_W'(node_count_r);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(node_count_r);
  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = obuf_r;
  assign top_node = snode_r[NODE_W'(depth_r - 1'b1)];
  assign top_next = snext_r[NODE_W'(depth_r - 1'b1)];

  assign we = in_ch.valid && in_ch.ready && ind.cmd == CMD_LOAD
              && ecnt_r[ind.from_node] < ECNT_W'(EDGES_PER_NODE);
  assign waddr = EADDR_W'({ind.from_node, EPN_W'(ecnt_r[ind.from_node])});
  assign wdata = {ind.to_node, ind.field_index};
  assign raddr = EADDR_W'({top_node, EPN_W'(top_next)});

  assign out_load = (in_ch.valid && in_ch.ready && ind.cmd == CMD_LOAD && !we)
                    || (state_r == S_ROOT && root_r >= nc)
                    || (state_r == S_EMIT && (!ovalid_r || out_ch.ready));

  ocf_ram #(.WIDTH(NODE_W + 6), .DEPTH(NODES * EDGES_PER_NODE)) u_edges (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      node_count_r <= NCNT_W'(16);
      depth_r <= '0;
      root_r <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        ecnt_r[i] <= '0;
        col_r[i] <= COL_WHITE;
      end
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_NODE_COUNT) begin
        node_count_r <= cfg_pwdata[NCNT_W-1:0];
      end
      if (out_load) begin
        ovalid_r <= 1'b1;
      end else if (ovalid_r && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            case (ind.cmd)
              CMD_LOAD: begin
                if (we) begin
                  ecnt_r[ind.from_node] <= ecnt_r[ind.from_node] + 1'b1;
                end else begin
                  obuf_r <= '{ST_DROP, ind.from_node, ind.field_index, ind.to_node, 1'b1};
                end
              end
              CMD_CLEAR: begin
                for (int i = 0; i < NODES; i++) begin
                  ecnt_r[i] <= '0;
                  col_r[i] <= COL_WHITE;
                end
                depth_r <= '0;
                root_r <= '0;
              end
              CMD_FIND: state_r <= (depth_r == '0) ? S_ROOT : S_TOP;
              default: ;
            endcase
          end
        end
        S_ROOT: begin
          if (root_r >= nc) begin
            obuf_r <= '{ST_DONE, '0, '0, '0, 1'b1};
            state_r <= S_IDLE;
          end else if (col_r[NODE_W'(root_r)] != COL_WHITE) begin
            root_r <= root_r + 1'b1;
          end else begin
            col_r[NODE_W'(root_r)] <= COL_GREY;
            snode_r[0] <= NODE_W'(root_r);
            snext_r[0] <= '0;
            depth_r <= DEPTH_W'(1);
            state_r <= S_TOP;
          end
        end
        S_TOP: begin
          at_r <= top_node;
          if (top_next >= ecnt_r[top_node]) begin
            col_r[top_node] <= COL_BLACK;
            depth_r <= depth_r - 1'b1;
            state_r <= (depth_r == DEPTH_W'(1)) ? S_ROOT : S_TOP;
          end else begin
            snext_r[NODE_W'(depth_r - 1'b1)] <= top_next + 1'b1;
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          tgt_r <= rdata[NODE_W+5:6];
          fld_r <= rdata[5:0];
          pos_r <= '0;
          if (DEPTH_W'(rdata[NODE_W+5:6]) >= nc) begin
            state_r <= S_TOP;
          end else if (col_r[rdata[NODE_W+5:6]] == COL_GREY) begin
            state_r <= S_SCAN;
          end else begin
            if (col_r[rdata[NODE_W+5:6]] == COL_WHITE && depth_r < DEPTH_W'(NODES)) begin
              col_r[rdata[NODE_W+5:6]] <= COL_GREY;
              snode_r[NODE_W'(depth_r)] <= rdata[NODE_W+5:6];
              snext_r[NODE_W'(depth_r)] <= '0;
              depth_r <= depth_r + 1'b1;
            end
            state_r <= S_TOP;
          end
        end
        S_SCAN: begin
          if (pos_r >= depth_r) begin
            state_r <= S_TOP;
          end else if (snode_r[NODE_W'(pos_r)] == tgt_r) begin
            state_r <= S_EMIT;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (!ovalid_r || out_ch.ready) begin
            obuf_r <= '{ST_RING, at_r, fld_r, snode_r[NODE_W'(pos_r)],
                        pos_r + 1'b1 == depth_r};
            pos_r <= pos_r + 1'b1;
            if (pos_r + 1'b1 == depth_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(NODES)) else $error("stack overflow");
  a_emit_grey: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> col_r[tgt_r] == COL_GREY) else $error("ring target not on stack");
`endif
endmodule
`default_nettype wire
